[design/pte_pkg.sv]
// Shared types, codes and constants of the partition table engine.
package pte_pkg;

   // Default table depth
   localparam int SLOTS_DEF = 128;

   // Configuration reset values
   localparam logic [63:0] USABLE_LOW_RST   = 64'd34;
   localparam logic [63:0] USABLE_HIGH_RST  = 64'd0;
   localparam logic [7:0]  SLOTS_IN_USE_RST = 8'd128;

   // Configuration register indexes
   localparam logic [1:0] CSR_USABLE_LOW   = 2'd0;
   localparam logic [1:0] CSR_USABLE_HIGH  = 2'd1;
   localparam logic [1:0] CSR_SLOTS_IN_USE = 2'd2;

   // Request modes
   localparam logic [1:0] MODE_CREATE = 2'd0;
   localparam logic [1:0] MODE_DELETE = 2'd1;
   localparam logic [1:0] MODE_SET    = 2'd2;
   localparam logic [1:0] MODE_INFO   = 2'd3;

   // Result status codes
   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_INVALID  = 3'd1;
   localparam logic [2:0] ST_EXISTS   = 3'd2;
   localparam logic [2:0] ST_NOSPACE  = 3'd3;
   localparam logic [2:0] ST_NOTFOUND = 3'd4;

   // One table entry as stored in memory
   typedef struct packed {
      logic [63:0] type_high;
      logic [63:0] type_low;
      logic [63:0] last;
      logic [63:0] first;
      logic        used;
   } entry_type;

   // Memory access controls from the sequencer
   typedef struct packed {
      logic rd_en;
      logic wr_en;
   } mem_ctl_type;

endpackage

[design/pte_table.sv]
// Slot table memory: one write port and one registered read port.
module pte_table #(
   parameter int SLOTS = pte_pkg::SLOTS_DEF,
   parameter int AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
   input  logic                clock,
   input  pte_pkg::mem_ctl_type mem_ctl,
   input  logic [AW-1:0]       mem_addr,
   input  pte_pkg::entry_type  mem_wdata,
   output pte_pkg::entry_type  mem_rdata
);
   import pte_pkg::*;

   entry_type mem [SLOTS];

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (mem_ctl.wr_en) begin
         mem[mem_addr] <= mem_wdata;
      end
      if (mem_ctl.rd_en) begin
         mem_rdata <= mem[mem_addr];
      end
   end

endmodule

[design/pte_ctrl.sv]
// Request sequencer: clearing pass, slot lookup, placement scan and result register.
module pte_ctrl #(
   parameter int SLOTS = pte_pkg::SLOTS_DEF,
   parameter int AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1,
   parameter int CW    = $clog2(SLOTS + 1)
) (
   input  logic                 clock,
   input  logic                 reset,
   // configuration values
   input  logic [63:0]          usable_low,
   input  logic [63:0]          usable_high,
   input  logic [7:0]           slots_in_use,
   // request side
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [1:0]           req_mode,
   input  logic [7:0]           req_slot,
   input  logic [63:0]          req_size,
   input  logic [63:0]          req_type_low,
   input  logic [63:0]          req_type_high,
   // response side
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [2:0]           rsp_status,
   output logic [63:0]          rsp_start,
   output logic [63:0]          rsp_size,
   // table memory
   output pte_pkg::mem_ctl_type mem_ctl,
   output logic [AW-1:0]        mem_addr,
   output pte_pkg::entry_type   mem_wdata,
   input  pte_pkg::entry_type   mem_rdata
);
   import pte_pkg::*;

   localparam logic [2:0] S_CLEAR  = 3'd0;
   localparam logic [2:0] S_IDLE   = 3'd1;
   localparam logic [2:0] S_EVAL   = 3'd2;
   localparam logic [2:0] S_SCAN   = 3'd3;
   localparam logic [2:0] S_PLACE  = 3'd4;
   localparam logic [2:0] S_COMMIT = 3'd5;
   localparam logic [2:0] S_OUT    = 3'd6;

   localparam logic [CW+7:0] SLOTS_W = (CW + 8)'(SLOTS);
   localparam logic [AW-1:0] LAST_ADDR = AW'(SLOTS - 1);

   logic [2:0]    state_ff, state_in;
   logic [AW-1:0] clr_ff, clr_in;
   logic [CW-1:0] scan_ff, scan_in;
   logic          pend_ff, pend_in;
   logic [CW-1:0] count_ff, count_in;
   logic [1:0]    mode_ff, mode_in;
   logic [AW-1:0] slot_ff, slot_in;
   logic [63:0]   size_ff, size_in;
   logic [63:0]   tlo_ff, tlo_in;
   logic [63:0]   thi_ff, thi_in;
   logic [63:0]   next_ff, next_in;
   logic [63:0]   avail_ff, avail_in;
   logic          nospace_ff, nospace_in;
   logic [2:0]    res_status_ff, res_status_in;
   logic [63:0]   res_start_ff, res_start_in;
   logic [63:0]   res_size_ff, res_size_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [2:0]    rsp_status_ff, rsp_status_in;
   logic [63:0]   rsp_start_ff, rsp_start_in;
   logic [63:0]   rsp_size_ff, rsp_size_in;

   logic [CW+7:0] siu_wide, cnt_wide, slot_wide;
   logic          accept, scan_issue;
   logic [63:0]   scan_end, want;
   entry_type     upd_entry;

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;

   // Addressable slot count and slot check
   assign siu_wide  = {{CW{1'b0}}, slots_in_use};
   assign cnt_wide  = (siu_wide < SLOTS_W) ? siu_wide : SLOTS_W;
   assign slot_wide = {{CW{1'b0}}, req_slot};

   assign scan_issue = (scan_ff < count_ff);
   assign scan_end   = mem_rdata.last + 64'd1;
   assign want       = (size_ff == 64'd0) ? avail_ff : size_ff;

   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      scan_in       = scan_ff;
      pend_in       = 1'b0;
      count_in      = count_ff;
      mode_in       = mode_ff;
      slot_in       = slot_ff;
      size_in       = size_ff;
      tlo_in        = tlo_ff;
      thi_in        = thi_ff;
      next_in       = next_ff;
      avail_in      = avail_ff;
      nospace_in    = nospace_ff;
      res_status_in = res_status_ff;
      res_start_in  = res_start_ff;
      res_size_in   = res_size_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_start_in  = rsp_start_ff;
      rsp_size_in   = rsp_size_ff;
      mem_ctl       = '0;
      mem_addr      = slot_ff;
      mem_wdata     = '0;
      upd_entry     = mem_rdata;

      case (state_ff)
         // Zero every entry after reset
         S_CLEAR: begin
            mem_ctl.wr_en = 1'b1;
            mem_addr      = clr_ff;
            clr_in        = clr_ff + AW'(1);
            if (clr_ff == LAST_ADDR) begin
               state_in = S_IDLE;
            end
         end
         // Take an item and read its slot, or flag an invalid slot
         S_IDLE: begin
            mem_addr = slot_wide[AW-1:0];
            if (accept) begin
               mode_in  = req_mode;
               slot_in  = slot_wide[AW-1:0];
               size_in  = req_size;
               tlo_in   = req_type_low;
               thi_in   = req_type_high;
               count_in = cnt_wide[CW-1:0];
               res_start_in = 64'd0;
               res_size_in  = 64'd0;
               if (slot_wide < cnt_wide) begin
                  mem_ctl.rd_en = 1'b1;
                  state_in      = S_EVAL;
               end else begin
                  res_status_in = ST_INVALID;
                  state_in      = S_OUT;
               end
            end
         end
         // Decide on the slot contents
         S_EVAL: begin
            res_status_in = ST_OK;
            state_in      = S_OUT;
            if (mode_ff == MODE_CREATE) begin
               if (mem_rdata.used) begin
                  res_status_in = ST_EXISTS;
               end else begin
                  scan_in  = '0;
                  next_in  = usable_low;
                  state_in = S_SCAN;
               end
            end else if (!mem_rdata.used) begin
               res_status_in = ST_NOTFOUND;
            end else if (mode_ff == MODE_DELETE) begin
               mem_ctl.wr_en = 1'b1;
            end else if (mode_ff == MODE_SET) begin
               upd_entry.type_low  = tlo_ff;
               upd_entry.type_high = thi_ff;
               mem_wdata     = upd_entry;
               mem_ctl.wr_en = 1'b1;
            end else begin
               res_start_in = mem_rdata.first;
               res_size_in  = mem_rdata.last - mem_rdata.first + 64'd1;
            end
         end
         // Stream slots below the count and track the highest end
         S_SCAN: begin
            mem_addr      = scan_ff[AW-1:0];
            mem_ctl.rd_en = scan_issue;
            pend_in       = scan_issue;
            if (scan_issue) begin
               scan_in = scan_ff + CW'(1);
            end
            if (pend_ff && mem_rdata.used && (scan_end > next_ff)) begin
               next_in = scan_end;
            end
            if (!scan_issue && !pend_ff) begin
               state_in = S_PLACE;
            end
         end
         // Free space after the placement point
         S_PLACE: begin
            nospace_in = (next_ff > usable_high);
            avail_in   = usable_high - next_ff + 64'd1;
            state_in   = S_COMMIT;
         end
         // Check the size and, if it fits, write the new entry
         S_COMMIT: begin
            state_in = S_OUT;
            if (nospace_ff || (want == 64'd0) || (want > avail_ff)) begin
               res_status_in = ST_NOSPACE;
            end else begin
               upd_entry.used      = 1'b1;
               upd_entry.first     = next_ff;
               upd_entry.last      = next_ff + want - 64'd1;
               upd_entry.type_low  = tlo_ff;
               upd_entry.type_high = thi_ff;
               mem_wdata     = upd_entry;
               mem_ctl.wr_en = 1'b1;
               res_status_in = ST_OK;
               res_start_in  = next_ff;
               res_size_in   = want;
            end
         end
         // Hand the result to the output register once it is free
         S_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_start_in  = res_start_ff;
               rsp_size_in   = res_size_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      scan_ff       <= scan_in;
      count_ff      <= count_in;
      mode_ff       <= mode_in;
      slot_ff       <= slot_in;
      size_ff       <= size_in;
      tlo_ff        <= tlo_in;
      thi_ff        <= thi_in;
      next_ff       <= next_in;
      avail_ff      <= avail_in;
      nospace_ff    <= nospace_in;
      res_status_ff <= res_status_in;
      res_start_ff  <= res_start_in;
      res_size_ff   <= res_size_in;
      rsp_status_ff <= rsp_status_in;
      rsp_start_ff  <= rsp_start_in;
      rsp_size_ff   <= rsp_size_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_start  = rsp_start_ff;
   assign rsp_size   = rsp_size_ff;

endmodule

[design/partition_table_engine_unit.sv]
// Path from the accepting edge to rsp_tvalid: an invalid slot goes straight to the result state;
// delete, set type, get info and create on a used slot pass slot evaluation first; create on a free
// slot adds a placement scan of count slots (count <= SLOTS), one slot per cycle through the single
// table read port, then placement and commit. One item is in work at a time: req_tready rises with
// rsp_tvalid; a result waits while an earlier one is held for rsp_tready. Reset is synchronous: it
// restores control and csr registers, clears every slot with req_tready low; csr_ready is high.
module partition_table_engine_unit #(
   parameter int SLOTS = pte_pkg::SLOTS_DEF
) (
   input  logic          clock,
   input  logic          reset,
   // configuration write channel
   input  logic          csr_valid,
   output logic          csr_ready,
   input  logic [1:0]    csr_index,
   input  logic [63:0]   csr_data,
   // request channel
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [199:0]  req_tdata,  // entry_slot[7:0], request_size, type_low, type_high
   input  logic [1:0]    req_tuser,  // mode
   // response channel
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [127:0]  rsp_tdata,  // part_start[63:0], part_size[127:64]
   output logic [2:0]    rsp_tuser   // status
);
   import pte_pkg::*;

   localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CW = $clog2(SLOTS + 1);

   logic [63:0] usable_low_ff, usable_high_ff;
   logic [7:0]  slots_in_use_ff;

   mem_ctl_type   mem_ctl;
   logic [AW-1:0] mem_addr;
   entry_type     mem_wdata, mem_rdata;
   logic [2:0]    rsp_status;
   logic [63:0]   rsp_start, rsp_size;

   assign csr_ready = 1'b1;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         usable_low_ff   <= USABLE_LOW_RST;
         usable_high_ff  <= USABLE_HIGH_RST;
         slots_in_use_ff <= SLOTS_IN_USE_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_USABLE_LOW:   usable_low_ff   <= csr_data;
            CSR_USABLE_HIGH:  usable_high_ff  <= csr_data;
            CSR_SLOTS_IN_USE: slots_in_use_ff <= csr_data[7:0];
            default: begin
            end
         endcase
      end
   end

   pte_ctrl #(
      .SLOTS (SLOTS),
      .AW    (AW),
      .CW    (CW)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .usable_low    (usable_low_ff),
      .usable_high   (usable_high_ff),
      .slots_in_use  (slots_in_use_ff),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_mode      (req_tuser),
      .req_slot      (req_tdata[7:0]),
      .req_size      (req_tdata[71:8]),
      .req_type_low  (req_tdata[135:72]),
      .req_type_high (req_tdata[199:136]),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_status    (rsp_status),
      .rsp_start     (rsp_start),
      .rsp_size      (rsp_size),
      .mem_ctl       (mem_ctl),
      .mem_addr      (mem_addr),
      .mem_wdata     (mem_wdata),
      .mem_rdata     (mem_rdata)
   );

   pte_table #(
      .SLOTS (SLOTS),
      .AW    (AW)
   ) u_table (
      .clock     (clock),
      .mem_ctl   (mem_ctl),
      .mem_addr  (mem_addr),
      .mem_wdata (mem_wdata),
      .mem_rdata (mem_rdata)
   );

   assign rsp_tdata = {rsp_size, rsp_start};
   assign rsp_tuser = rsp_status;

endmodule
